// ===== rtl/core/akf_pkg.sv =====
// akf_pkg: shared types and constants for the angle kalman filter
// no dependencies
package akf_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned NoiseW = 31;
  localparam int unsigned DtW = 24;
  localparam int unsigned FracBits = 24;
  localparam int unsigned AddrW = 4;
  localparam logic [NoiseW-1:0] AngleNoiseReset = 31'd16777;
  localparam logic [NoiseW-1:0] BiasNoiseReset = 31'd50332;
  localparam logic [NoiseW-1:0] MeasureNoiseReset = 31'd503316;
  localparam logic [AddrW-1:0] RegAngleNoise = 4'h0;
  localparam logic [AddrW-1:0] RegBiasNoise = 4'h4;
  localparam logic [AddrW-1:0] RegMeasureNoise = 4'h8;

  typedef logic signed [63:0] wide_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // product rescaled by 2^-24, round half up (floor after bias)
  function automatic logic signed [65:0] rescale(input logic signed [65:0] p);
    logic signed [65:0] b;
    b = p + 66'sd8388608;
    return b >>> FracBits;
  endfunction
endpackage

// ===== rtl/core/akf_div.sv =====
// akf_div: radix-2 restoring divider, signed, truncate toward zero
// depends on akf_pkg
module akf_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic done,
  output logic signed [63:0] quo
);
  import akf_pkg::*;
  logic [63:0] n_mag, d_mag, q, r;
  logic [6:0] cnt;
  logic busy, neg;
  logic [64:0] r_sh;

  assign r_sh = {r, q[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        q <= num[63] ? -num : num;
        r <= '0;
        d_mag <= den[63] ? -den : den;
        neg <= num[63] ^ den[63];
      end else if (busy) begin
        if (r_sh >= {1'b0, d_mag}) begin
          r <= 64'(r_sh - {1'b0, d_mag});
          q <= {q[62:0], 1'b1};
        end else begin
          r <= r_sh[63:0];
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign n_mag = q;
  assign quo = neg ? -n_mag : n_mag;
endmodule

// ===== rtl/core/angle_kalman_filter.sv =====
// angle_kalman_filter: two-state kalman filter for angle and gyro bias
// depends on akf_pkg and akf_div
// an item passes through two divides plus 15 steps from accept to result valid
// in_ready low while an item is worked on
// the result waits in an output register; a new item is taken meanwhile
// reset clears estimates and covariance and restores the noise registers
module angle_kalman_filter
  import akf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_rate,
  input  logic [23:0] time_step,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] filtered_angle,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_ANG, S_T, S_INNER, S_P00, S_P11, S_S, S_DIV0, S_DIV1,
    S_Y, S_ANG2, S_BIAS, S_C0, S_C1, S_C2, S_C3, S_OUT
  } state_t;

  state_t state;
  logic [NoiseW-1:0] angle_noise, bias_noise, measure_noise;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] m_ang, m_rate, rate, k0, k1, y, o00, o01;
  logic [23:0] dt;
  logic signed [65:0] t, inner, s;
  logic signed [32:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [65:0] prod, rnd;
  logic div_start, div_done;
  logic signed [63:0] div_num, div_quo;

  assign pready = 1'b1;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (paddr)
      RegAngleNoise: prdata = {1'b0, angle_noise};
      RegBiasNoise: prdata = {1'b0, bias_noise};
      RegMeasureNoise: prdata = {1'b0, measure_noise};
      default: prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ANG: begin mul_a = {9'd0, dt}; mul_b = {{3{rate[31]}}, rate}; end
      S_T: begin mul_a = {9'd0, dt}; mul_b = {{3{p11[31]}}, p11}; end
      S_P00: begin mul_a = {9'd0, dt}; mul_b = inner[34:0]; end
      S_P11: begin mul_a = {2'd0, bias_noise}; mul_b = {11'd0, dt}; end
      S_ANG2: begin mul_a = {k0[31], k0}; mul_b = {{3{y[31]}}, y}; end
      S_BIAS: begin mul_a = {k1[31], k1}; mul_b = {{3{y[31]}}, y}; end
      S_C0: begin mul_a = {k0[31], k0}; mul_b = {{3{o00[31]}}, o00}; end
      S_C1: begin mul_a = {k0[31], k0}; mul_b = {{3{o01[31]}}, o01}; end
      S_C2: begin mul_a = {k1[31], k1}; mul_b = {{3{o00[31]}}, o00}; end
      S_C3: begin mul_a = {k1[31], k1}; mul_b = {{3{o01[31]}}, o01}; end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign rnd = rescale(prod);

  akf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(s[63:0]), .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      angle_noise <= AngleNoiseReset;
      bias_noise <= BiasNoiseReset;
      measure_noise <= MeasureNoiseReset;
      ang <= '0; bias <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
    end else begin
      div_start <= 1'b0;
      if (state == S_OUT) begin
        if (!out_valid || out_ready) out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        case (paddr)
          RegAngleNoise: angle_noise <= pwdata[NoiseW-1:0];
          RegBiasNoise: bias_noise <= pwdata[NoiseW-1:0];
          RegMeasureNoise: measure_noise <= pwdata[NoiseW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          m_ang <= measured_angle; m_rate <= measured_rate; dt <= time_step;
          state <= S_RATE;
        end
        S_RATE: begin
          rate <= sat32(66'(m_rate) - 66'(bias));
          state <= S_ANG;
        end
        S_ANG: begin ang <= sat32(66'(ang) + rnd); state <= S_T; end
        S_T: begin t <= rnd; state <= S_INNER; end
        S_INNER: begin
          inner <= t - 66'(p01) - 66'(p10) + 66'($unsigned(angle_noise));
          p01 <= sat32(66'(p01) - t);
          p10 <= sat32(66'(p10) - t);
          state <= S_P00;
        end
        S_P00: begin p00 <= sat32(66'(p00) + rnd); state <= S_P11; end
        S_P11: begin p11 <= sat32(66'(p11) + rnd); state <= S_S; end
        S_S: begin
          s <= 66'(p00) + 66'($unsigned(measure_noise));
          div_num <= 64'(p00) <<< FracBits;
          div_start <= 1'b1;
          state <= S_DIV0;
        end
        S_DIV0: if (div_done) begin
          k0 <= (s == 0) ? '0 : sat32(66'(div_quo));
          div_num <= 64'(p10) <<< FracBits;
          div_start <= 1'b1;
          state <= S_DIV1;
        end
        S_DIV1: if (div_done) begin
          k1 <= (s == 0) ? '0 : sat32(66'(div_quo));
          state <= S_Y;
        end
        S_Y: begin
          y <= sat32(66'(m_ang) - 66'(ang));
          o00 <= p00; o01 <= p01;
          state <= S_ANG2;
        end
        S_ANG2: begin ang <= sat32(66'(ang) + rnd); state <= S_BIAS; end
        S_BIAS: begin bias <= sat32(66'(bias) + rnd); state <= S_C0; end
        S_C0: begin p00 <= sat32(66'(p00) - rnd); state <= S_C1; end
        S_C1: begin p01 <= sat32(66'(p01) - rnd); state <= S_C2; end
        S_C2: begin p10 <= sat32(66'(p10) - rnd); state <= S_C3; end
        S_C3: begin p11 <= sat32(66'(p11) - rnd); state <= S_OUT; end
        S_OUT: if (!out_valid || out_ready) begin
          filtered_angle <= ang;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("spurious result");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == S_DIV0 || state == S_DIV1)) else $error("bad divide start");
endmodule
